// ===== hdl/mrr_pkg.sv =====
// Shared types, constants and helpers for the Modbus RTU read-response receiver.
// No dependencies; the receiver unit and the CRC engine refer to this package by scoped names.
package mrr_pkg;

    localparam int MAX_FRAME_BYTES = 64;
    localparam int MAX_WORDS       = 16;
    localparam int FRAME_LEN_W     = 7;
    localparam int WORD_IDX_W      = 4;
    localparam int WORD_CNT_W      = 5;

    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [2:0]  CRC_STEP_LAST = 3'd7;

    localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0] MAX_BYTE_COUNT    = 8'h20;
    localparam logic [FRAME_LEN_W-1:0] MIN_FRAME_LEN = FRAME_LEN_W'(5);
    localparam logic [FRAME_LEN_W-1:0] HEADER_LEN    = FRAME_LEN_W'(3);

    // configuration register indexes
    localparam logic REG_STATION_ADDRESS = 1'b0;
    localparam logic REG_GAP_TICKS       = 1'b1;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_ADDRESS   = 3'd1,
        ST_CRC       = 3'd2,
        ST_FUNCTION  = 3'd3,
        ST_COUNT_BIG = 3'd4,
        ST_SHORT     = 3'd5,
        ST_OVERFLOW  = 3'd6
    } status_t;

    typedef struct packed {
        logic clear;
        logic start;
    } crc_ctrl_t;

    // one bit of the reflected CRC-16/MODBUS update
    function automatic logic [15:0] crc_shift(input logic [15:0] c);
        crc_shift = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    endfunction

endpackage

// ===== hdl/mrr_if.sv =====
// Valid/ready channel interfaces for the receiver's input and result beats.
// Depends on nothing; widths follow the field list of the block.
interface mrr_in_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] byte_value;

    modport source (output valid, action, byte_value, input ready);
    modport sink   (input valid, action, byte_value, output ready);
endinterface

interface mrr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic        has_word;
    logic [3:0]  reg_index;
    logic [15:0] reg_value;
    logic        last;

    modport source (output valid, status, has_word, reg_index, reg_value, last, input ready);
    modport sink   (input valid, status, has_word, reg_index, reg_value, last, output ready);
endinterface

// ===== hdl/modbus_rtu_read_response_receiver_unit.sv =====
// Top level of the Modbus RTU function-03 response receiver.
// Depends on mrr_pkg, mrr_in_if / mrr_out_if and mrr_crc_serial.
//
// Usage:
//   in_ch carries one beat per UART event: action 0 with a received byte, or
//   action 1 for an idle tick. A frame closes on the tick that brings the
//   count of ticks since the last byte up to gap_ticks (zero acts as one).
//   out_ch carries the results of a closed frame: one beat per big-endian
//   register word (has_word 1, last on the final one), or a single status
//   beat with last set when the frame is rejected or holds no words.
//   Configuration (cfg_we, cfg_index, cfg_data) is written while idle.
// Timing:
//   A byte beat from the third on occupies the block until the bit-serial
//   CRC engine has folded the oldest held byte in, one bit per cycle; ready
//   stays low until it is done. The first two bytes, bytes past the frame
//   limit and ticks that do not close a frame do not hold off input. A closing
//   tick runs a registered read and an output load for each result beat,
//   plus any out_ch stall; input is held off until the final beat is loaded.
// Reset:
//   rst_n clears all frame state, the CRC to 0xFFFF, station_address to 1 and
//   gap_ticks to 5. The word store needs no clearing: only words written by
//   the current frame are ever read.
module modbus_rtu_read_response_receiver_unit
(
    input  logic        clk,
    input  logic        rst_n,
    mrr_in_if.sink      in_ch,
    mrr_out_if.source   out_ch,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } state_t;

    localparam int LW = mrr_pkg::FRAME_LEN_W;

    state_t state_reg, state_next;

    // configuration
    logic [7:0] station_reg, station_next;
    logic [7:0] gap_reg,     gap_next;

    // frame state
    logic [7:0]    held0_reg, held0_next;
    logic [7:0]    held1_reg, held1_next;
    logic [7:0]    hdr0_reg,  hdr0_next;
    logic [7:0]    hdr1_reg,  hdr1_next;
    logic [7:0]    hdr2_reg,  hdr2_next;
    logic [LW-1:0] len_reg,   len_next;
    logic [7:0]    idle_reg,  idle_next;
    logic          ovf_reg,   ovf_next;

    // result sequencing
    mrr_pkg::status_t                  st_reg, st_next;
    logic [mrr_pkg::WORD_CNT_W-1:0]    words_reg, words_next;
    logic [mrr_pkg::WORD_IDX_W-1:0]    idx_reg, idx_next;

    // output register
    logic        ov_reg,   ov_next;
    logic [2:0]  ost_reg,  ost_next;
    logic        ohw_reg,  ohw_next;
    logic [3:0]  oidx_reg, oidx_next;
    logic [15:0] oval_reg, oval_next;
    logic        olast_reg, olast_next;

    // word store: high and low bytes kept apart for byte-wide writes
    logic [7:0] hi_mem [mrr_pkg::MAX_WORDS];
    logic [7:0] lo_mem [mrr_pkg::MAX_WORDS];
    logic [7:0] rd_hi_reg, rd_lo_reg;
    logic       mem_we_hi, mem_we_lo, rd_en;
    logic [mrr_pkg::WORD_IDX_W-1:0] mem_addr;

    // CRC engine
    mrr_pkg::crc_ctrl_t crc_ctrl;
    logic [15:0]        crc_val;
    logic               crc_busy;

    logic             in_ready;
    logic             in_fire;
    logic             out_free;
    logic [LW-1:0]    offs;
    logic [7:0]       idle_inc;
    mrr_pkg::status_t close_st;
    logic [8:0]       need_len;
    logic [mrr_pkg::WORD_CNT_W-1:0] close_words;
    logic [mrr_pkg::WORD_CNT_W-1:0] idx_plus;

    mrr_crc_serial u_crc
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (crc_ctrl),
        .data  (held0_reg),
        .crc   (crc_val),
        .busy  (crc_busy)
    );

    assign in_ready = (state_reg == S_IDLE) && !crc_busy;
    assign in_fire  = in_ch.valid && in_ready;
    assign out_free = !ov_reg || out_ch.ready;

    // offset of a payload byte past address, function and byte count
    assign offs     = len_reg - mrr_pkg::HEADER_LEN;
    assign idle_inc = (idle_reg == 8'hFF) ? idle_reg : idle_reg + 8'd1;
    assign need_len = {1'b0, hdr2_reg} + 9'd5;
    assign idx_plus = {1'b0, idx_reg} + mrr_pkg::WORD_CNT_W'(1);

    // frame checks, in priority order
    always_comb
    begin
        close_st = mrr_pkg::ST_OK;
        if (ovf_reg)
        begin
            close_st = mrr_pkg::ST_OVERFLOW;
        end
        else if (len_reg < mrr_pkg::MIN_FRAME_LEN)
        begin
            close_st = mrr_pkg::ST_SHORT;
        end
        else if (hdr0_reg != station_reg)
        begin
            close_st = mrr_pkg::ST_ADDRESS;
        end
        else if (held0_reg != crc_val[7:0] || held1_reg != crc_val[15:8])
        begin
            close_st = mrr_pkg::ST_CRC;
        end
        else if (hdr1_reg != mrr_pkg::FUNC_READ_HOLDING)
        begin
            close_st = mrr_pkg::ST_FUNCTION;
        end
        else if (hdr2_reg > mrr_pkg::MAX_BYTE_COUNT)
        begin
            close_st = mrr_pkg::ST_COUNT_BIG;
        end
        else if ({2'b00, len_reg} < need_len)
        begin
            close_st = mrr_pkg::ST_SHORT;
        end
    end

    // byte count is at most 32 once accepted, so the word count fits
    assign close_words = hdr2_reg[mrr_pkg::WORD_CNT_W:1];

    always_comb
    begin
        state_next   = state_reg;
        station_next = station_reg;
        gap_next     = gap_reg;
        held0_next   = held0_reg;
        held1_next   = held1_reg;
        hdr0_next    = hdr0_reg;
        hdr1_next    = hdr1_reg;
        hdr2_next    = hdr2_reg;
        len_next     = len_reg;
        idle_next    = idle_reg;
        ovf_next     = ovf_reg;
        st_next      = st_reg;
        words_next   = words_reg;
        idx_next     = idx_reg;
        ov_next      = ov_reg;
        ost_next     = ost_reg;
        ohw_next     = ohw_reg;
        oidx_next    = oidx_reg;
        oval_next    = oval_reg;
        olast_next   = olast_reg;
        crc_ctrl     = '0;
        mem_we_hi    = 1'b0;
        mem_we_lo    = 1'b0;
        mem_addr     = idx_reg;
        rd_en        = 1'b0;

        // drop the output beat once taken; a new load below overrides
        if (ov_reg && out_ch.ready)
        begin
            ov_next = 1'b0;
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                mrr_pkg::REG_STATION_ADDRESS: station_next = cfg_data;
                mrr_pkg::REG_GAP_TICKS:       gap_next     = cfg_data;
                default:                      station_next = station_reg;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && in_ch.action == mrr_pkg::ACT_BYTE)
                begin
                    idle_next = 8'd0;
                    if (len_reg >= LW'(mrr_pkg::MAX_FRAME_BYTES))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        // the byte leaving the hold pair enters the CRC
                        crc_ctrl.start = (len_reg >= LW'(2));
                        held0_next     = held1_reg;
                        held1_next     = in_ch.byte_value;
                        len_next       = len_reg + LW'(1);
                        if (len_reg == LW'(0))
                        begin
                            hdr0_next = in_ch.byte_value;
                        end
                        else if (len_reg == LW'(1))
                        begin
                            hdr1_next = in_ch.byte_value;
                        end
                        else if (len_reg == LW'(2))
                        begin
                            hdr2_next = in_ch.byte_value;
                        end
                        else if (offs < LW'(2 * mrr_pkg::MAX_WORDS))
                        begin
                            mem_addr  = offs[mrr_pkg::WORD_IDX_W:1];
                            mem_we_hi = !offs[0];
                            mem_we_lo = offs[0];
                        end
                    end
                end
                else if (in_fire && (len_reg != LW'(0) || ovf_reg))
                begin
                    idle_next = idle_inc;
                    if (idle_inc >= gap_reg)
                    begin
                        st_next        = close_st;
                        words_next     = close_words;
                        idx_next       = '0;
                        state_next     = S_READ;
                        // return frame state to reset
                        crc_ctrl.clear = 1'b1;
                        held0_next     = 8'd0;
                        held1_next     = 8'd0;
                        hdr0_next      = 8'd0;
                        hdr1_next      = 8'd0;
                        hdr2_next      = 8'd0;
                        len_next       = '0;
                        idle_next      = 8'd0;
                        ovf_next       = 1'b0;
                    end
                end
            end

            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_LOAD;
            end

            S_LOAD:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                    if (st_reg != mrr_pkg::ST_OK || words_reg == '0)
                    begin
                        ost_next   = st_reg;
                        ohw_next   = 1'b0;
                        oidx_next  = 4'd0;
                        oval_next  = 16'd0;
                        olast_next = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        ost_next   = mrr_pkg::ST_OK;
                        ohw_next   = 1'b1;
                        oidx_next  = idx_reg;
                        oval_next  = {rd_hi_reg, rd_lo_reg};
                        olast_next = (idx_plus == words_reg);
                        if (idx_plus == words_reg)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            idx_next   = idx_reg + mrr_pkg::WORD_IDX_W'(1);
                            state_next = S_READ;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            station_reg <= 8'd1;
            gap_reg     <= 8'd5;
            held0_reg   <= 8'd0;
            held1_reg   <= 8'd0;
            hdr0_reg    <= 8'd0;
            hdr1_reg    <= 8'd0;
            hdr2_reg    <= 8'd0;
            len_reg     <= '0;
            idle_reg    <= 8'd0;
            ovf_reg     <= 1'b0;
            st_reg      <= mrr_pkg::ST_OK;
            words_reg   <= '0;
            idx_reg     <= '0;
            ov_reg      <= 1'b0;
            ost_reg     <= 3'd0;
            ohw_reg     <= 1'b0;
            oidx_reg    <= 4'd0;
            oval_reg    <= 16'd0;
            olast_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            station_reg <= station_next;
            gap_reg     <= gap_next;
            held0_reg   <= held0_next;
            held1_reg   <= held1_next;
            hdr0_reg    <= hdr0_next;
            hdr1_reg    <= hdr1_next;
            hdr2_reg    <= hdr2_next;
            len_reg     <= len_next;
            idle_reg    <= idle_next;
            ovf_reg     <= ovf_next;
            st_reg      <= st_next;
            words_reg   <= words_next;
            idx_reg     <= idx_next;
            ov_reg      <= ov_next;
            ost_reg     <= ost_next;
            ohw_reg     <= ohw_next;
            oidx_reg    <= oidx_next;
            oval_reg    <= oval_next;
            olast_reg   <= olast_next;
        end
    end

    // word store: byte-wide writes, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we_hi)
        begin
            hi_mem[mem_addr] <= in_ch.byte_value;
        end
        if (mem_we_lo)
        begin
            lo_mem[mem_addr] <= in_ch.byte_value;
        end
        if (rd_en)
        begin
            rd_hi_reg <= hi_mem[idx_reg];
            rd_lo_reg <= lo_mem[idx_reg];
        end
    end

    assign in_ch.ready      = in_ready;
    assign out_ch.valid     = ov_reg;
    assign out_ch.status    = ost_reg;
    assign out_ch.has_word  = ohw_reg;
    assign out_ch.reg_index = oidx_reg;
    assign out_ch.reg_value = oval_reg;
    assign out_ch.last      = olast_reg;

endmodule

// ===== hdl/mrr_crc_serial.sv =====
// Bit-serial CRC-16/MODBUS engine: folds one byte in bit by bit, busy until done.
// Depends on mrr_pkg (crc_ctrl_t, crc_shift, CRC constants).
module mrr_crc_serial
(
    input  logic               clk,
    input  logic               rst_n,
    input  mrr_pkg::crc_ctrl_t ctrl,
    input  logic [7:0]         data,
    output logic [15:0]        crc,
    output logic               busy
);

    logic [15:0] crc_reg,  crc_next;
    logic [2:0]  bits_reg, bits_next;
    logic        busy_reg, busy_next;

    always_comb
    begin
        crc_next  = crc_reg;
        bits_next = bits_reg;
        busy_next = busy_reg;
        if (ctrl.clear)
        begin
            crc_next  = mrr_pkg::CRC_INIT;
            busy_next = 1'b0;
        end
        else if (ctrl.start)
        begin
            // xor the byte in and take the first shift in the same cycle
            crc_next  = mrr_pkg::crc_shift(crc_reg ^ {8'h00, data});
            bits_next = 3'd1;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            crc_next  = mrr_pkg::crc_shift(crc_reg);
            bits_next = bits_reg + 3'd1;
            if (bits_reg == mrr_pkg::CRC_STEP_LAST)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg  <= mrr_pkg::CRC_INIT;
            bits_reg <= 3'd0;
            busy_reg <= 1'b0;
        end
        else
        begin
            crc_reg  <= crc_next;
            bits_reg <= bits_next;
            busy_reg <= busy_next;
        end
    end

    assign crc  = crc_reg;
    assign busy = busy_reg;

endmodule
